FILE: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, types and register codes for the ray-sphere intersection
// block.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // Field widths of the ray and hit channels.
    localparam int COORD_W = 24;
    localparam int DIR_W   = 18;
    localparam int RAD_W   = 23;
    localparam int DIST_W  = 27;

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIR_W-1:0]   t_dir;
    typedef logic signed [DIST_W-1:0]  t_dist;
    typedef logic        [RAD_W-1:0]   t_radius;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg_idx;

endpackage

FILE: design/rsi_ray_if.sv
// ----------------------------------------------------------------------------
// rsi_ray_if
// Request channel that carries one ray: origin and unit direction.
// ----------------------------------------------------------------------------
interface rsi_ray_if
    import rsi_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord origin_x;
    t_coord origin_y;
    t_coord origin_z;
    t_dir   dir_x;
    t_dir   dir_y;
    t_dir   dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

FILE: design/rsi_hit_if.sv
// ----------------------------------------------------------------------------
// rsi_hit_if
// Result channel that carries the hit flag and the near distance.
// ----------------------------------------------------------------------------
interface rsi_hit_if
    import rsi_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  hit;
    t_dist hit_dist;

    modport source (output valid, hit, hit_dist, input ready);
    modport sink   (input valid, hit, hit_dist, output ready);
endinterface

FILE: design/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Geometric ray-sphere test in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
// A ray request enters on i_ray (origin Q8.F, unit direction Q2.F) and one
// result leaves on o_hit for every request: the hit flag and the distance to
// the near root, Q11.F, which is zero when there is no hit.
// The sphere center and radius sit in four registers on the APB-style port:
// center x/y/z at 0x0/0x4/0x8 and the radius at 0xC. Write them only while
// no request is in flight.
// The pipe has five arithmetic stages (offset, products, sums, projection
// square, discriminant), 27 square-root stages that settle one result bit
// each, and the output register.
// Throughput is one request per cycle; the square-root pipe sets the depth.
// When the receiver stalls with a result waiting, the whole pipe holds and
// i_ray.ready drops; nothing is lost or repeated.
// Reset clears every valid bit and loads center 0 and radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsi_ray_if.sink           i_ray,
    rsi_hit_if.source         o_hit,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SQ_STEPS = 27;
    localparam int SQ_RAD_W = 2 * SQ_STEPS;
    localparam logic [26:0] TM_CLAMP = 27'h4000000;

    // Configuration registers.
    t_coord   r_center_x, r_center_y, r_center_z;
    t_radius  r_radius;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= RAD_W'(65536);
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_CENTER_X: r_center_x <= pwdata[COORD_W-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[COORD_W-1:0];
                REG_CENTER_Z: r_center_z <= pwdata[COORD_W-1:0];
                REG_RADIUS:   r_radius   <= pwdata[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_idx)
            REG_CENTER_X: prdata = {{(APB_DW-COORD_W){r_center_x[COORD_W-1]}}, r_center_x};
            REG_CENTER_Y: prdata = {{(APB_DW-COORD_W){r_center_y[COORD_W-1]}}, r_center_y};
            REG_CENTER_Z: prdata = {{(APB_DW-COORD_W){r_center_z[COORD_W-1]}}, r_center_z};
            REG_RADIUS:   prdata = {{(APB_DW-RAD_W){1'b0}}, r_radius};
            default:      prdata = '0;
        endcase
    end

    // The pipe advances as one unless a finished result is held up.
    logic w_en;
    logic r_out_vld;
    assign w_en        = !r_out_vld || o_hit.ready;
    assign i_ray.ready = w_en;

    // Stage 1: offset from origin to center.
    logic               r1_vld;
    logic signed [24:0] r1_lx, r1_ly, r1_lz;
    t_dir               r1_dx, r1_dy, r1_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_ray.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_lx <= 25'(r_center_x) - 25'(i_ray.origin_x);
            r1_ly <= 25'(r_center_y) - 25'(i_ray.origin_y);
            r1_lz <= 25'(r_center_z) - 25'(i_ray.origin_z);
            r1_dx <= i_ray.dir_x;
            r1_dy <= i_ray.dir_y;
            r1_dz <= i_ray.dir_z;
        end
    end

    // Stage 2: projection and length products, radius squared.
    logic               r2_vld;
    logic signed [42:0] r2_px, r2_py, r2_pz;
    logic signed [49:0] r2_qx, r2_qy, r2_qz;
    logic        [45:0] r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_px <= 43'(r1_lx) * 43'(r1_dx);
            r2_py <= 43'(r1_ly) * 43'(r1_dy);
            r2_pz <= 43'(r1_lz) * 43'(r1_dz);
            r2_qx <= 50'(r1_lx) * 50'(r1_lx);
            r2_qy <= 50'(r1_ly) * 50'(r1_ly);
            r2_qz <= 50'(r1_lz) * 50'(r1_lz);
            r2_rr <= 46'(r_radius) * 46'(r_radius);
        end
    end

    // Stage 3: dot-product sums, behind test, scaled and clamped projection.
    logic               r3_vld;
    logic               r3_behind;
    logic        [26:0] r3_tmq;
    logic        [50:0] r3_ll;
    logic        [45:0] r3_rr;
    logic signed [44:0] w_tm;
    logic        [44:0] w_tm_sh;

    assign w_tm    = 45'(r2_px) + 45'(r2_py) + 45'(r2_pz);
    assign w_tm_sh = w_tm >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_behind <= w_tm[44];
            r3_tmq    <= (w_tm_sh > 45'(TM_CLAMP)) ? TM_CLAMP : w_tm_sh[26:0];
            r3_ll     <= 51'(r2_qx[48:0]) + 51'(r2_qy[48:0]) + 51'(r2_qz[48:0]);
            r3_rr     <= r2_rr;
        end
    end

    // Stage 4: square of the projection.
    logic        r4_vld;
    logic        r4_behind;
    logic [26:0] r4_tmq;
    logic [53:0] r4_tq2;
    logic [50:0] r4_ll;
    logic [45:0] r4_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_behind <= r3_behind;
            r4_tmq    <= r3_tmq;
            r4_tq2    <= 54'(r3_tmq) * 54'(r3_tmq);
            r4_ll     <= r3_ll;
            r4_rr     <= r3_rr;
        end
    end

    // Stage 5: miss distance squared, reject test, square-root operand.
    logic signed [55:0] w_d2;
    logic signed [55:0] w_rad;
    logic               w_miss;

    assign w_d2   = $signed({5'd0, r4_ll}) - $signed({2'd0, r4_tq2});
    assign w_miss = w_d2 > $signed({10'd0, r4_rr});
    assign w_rad  = $signed({10'd0, r4_rr}) - w_d2;

    // Square-root pipe: index 0 is stage 5, each later index one result bit.
    logic                r_sq_vld  [0:SQ_STEPS];
    logic                r_sq_rej  [0:SQ_STEPS];
    logic [26:0]         r_sq_tmq  [0:SQ_STEPS];
    logic [SQ_RAD_W-1:0] r_sq_rad  [0:SQ_STEPS];
    logic [28:0]         r_sq_rem  [0:SQ_STEPS];
    logic [26:0]         r_sq_root [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_vld[0] <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rej[0]  <= r4_behind || w_miss;
            r_sq_tmq[0]  <= r4_tmq;
            r_sq_rad[0]  <= w_rad[SQ_RAD_W-1:0];
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [30:0] w_rem_sh;
        logic [30:0] w_trial;
        logic        w_take;

        // Bring down the next bit pair and try the next root bit.
        assign w_rem_sh = {r_sq_rem[k], r_sq_rad[k][SQ_RAD_W-1-2*k -: 2]};
        assign w_trial  = {2'b00, r_sq_root[k], 2'b01};
        assign w_take   = w_rem_sh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rej[k+1]  <= r_sq_rej[k];
                r_sq_tmq[k+1]  <= r_sq_tmq[k];
                r_sq_rad[k+1]  <= r_sq_rad[k];
                r_sq_rem[k+1]  <= w_take ? 29'(w_rem_sh - w_trial) : w_rem_sh[28:0];
                r_sq_root[k+1] <= {r_sq_root[k][25:0], w_take};
            end
        end
    end

    // Output stage: near root, saturated; zero on a miss.
    logic signed [28:0] w_dist;
    t_dist              w_dist_sat;
    logic               r_out_hit;
    t_dist              r_out_dist;

    assign w_dist = $signed({2'b00, r_sq_tmq[SQ_STEPS]})
                  - $signed({2'b00, r_sq_root[SQ_STEPS]});

    always_comb begin
        priority if (w_dist > 29'sd67108863) begin
            w_dist_sat = 27'sh3FFFFFF;
        end else if (w_dist < -29'sd67108864) begin
            w_dist_sat = 27'sh4000000;
        end else begin
            w_dist_sat = w_dist[26:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_sq_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit  <= !r_sq_rej[SQ_STEPS];
            r_out_dist <= r_sq_rej[SQ_STEPS] ? '0 : w_dist_sat;
        end
    end

    assign o_hit.valid    = r_out_vld;
    assign o_hit.hit      = r_out_hit;
    assign o_hit.hit_dist = r_out_dist;

endmodule

FILE: design/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for the ray-sphere intersection block.
// ----------------------------------------------------------------------------
module rsi_checker
    import rsi_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_ready,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input logic  i_out_hit,
    input t_dist i_out_dist,
    input logic  i_pready
);

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit)
            && $stable(i_out_dist))
        else $error("result changed while stalled");

    // A miss always reports zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_dist == '0)
        else $error("miss with nonzero distance");

    // Requests are taken whenever no result is waiting.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("pipe stalled with empty output");

    // Reset empties the pipe.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

    // The register port never waits.
    a_pready: assert property (@(posedge i_clk) i_pready)
        else $error("pready low");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_ray.ready),
    .i_out_valid(o_hit.valid),
    .i_out_ready(o_hit.ready),
    .i_out_hit  (o_hit.hit),
    .i_out_dist (o_hit.hit_dist),
    .i_pready   (pready)
);

FILE: tb/ray_sphere_intersect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_tb
// Self-checking bench for the ray-sphere intersection block. Rays are sent
// through the request channel, each expected hit result is computed by a
// bit-true predictor in the bench and compared in order with what the block
// returns. The sphere registers are set over the APB-style port between phases.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    localparam int  FRAC       = 16;
    localparam int  PIPE_DEPTH = 33;
    localparam longint DIST_HI = 64'sd67108863;
    localparam longint DIST_LO = -64'sd67108864;
    localparam longint TM_CAP  = 64'sd67108864;
    localparam int  CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic  hit;
        t_dist hit_dist;
    } t_hit_result;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    rsi_ray_if ray_ch ();
    rsi_hit_if hit_ch ();

    ray_sphere_intersect #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_ch.sink),
        .o_hit   (hit_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Sphere registers as the predictor sees them.
    t_coord  sph_cx;
    t_coord  sph_cy;
    t_coord  sph_cz;
    t_radius sph_r;

    t_hit_result expected_hits[$];
    int  error_count;
    int  cycle_count;
    bit  idle_on;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Truncating integer square root.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Predicts the hit flag and near distance for one ray.
    function automatic t_hit_result predict_hit(t_coord ox, t_coord oy, t_coord oz,
                                                t_dir dx, t_dir dy, t_dir dz);
        t_hit_result res;
        longint lx, ly, lz, tm_full, tmq, ll, d2, r2, dist_q;
        longint unsigned root;
        res = '0;
        lx = longint'(sph_cx) - longint'(ox);
        ly = longint'(sph_cy) - longint'(oy);
        lz = longint'(sph_cz) - longint'(oz);
        tm_full = lx * longint'(dx) + ly * longint'(dy) + lz * longint'(dz);
        if (tm_full < 0) return res;
        tmq = tm_full >>> FRAC;
        if (tmq > TM_CAP) tmq = TM_CAP;
        ll = lx * lx + ly * ly + lz * lz;
        d2 = ll - tmq * tmq;
        r2 = longint'({1'b0, sph_r}) * longint'({1'b0, sph_r});
        if (d2 > r2) return res;
        root = int_sqrt(longint'(r2 - d2));
        dist_q = tmq - longint'(root);
        if (dist_q > DIST_HI) dist_q = DIST_HI;
        if (dist_q < DIST_LO) dist_q = DIST_LO;
        res.hit      = 1'b1;
        res.hit_dist = t_dist'(dist_q);
        return res;
    endfunction

    // Prints one mismatch and counts it.
    task automatic report_error(string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Writes one sphere register during a quiet period.
    task automatic write_sphere_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CENTER_X: sph_cx = t_coord'(value);
            REG_CENTER_Y: sph_cy = t_coord'(value);
            REG_CENTER_Z: sph_cz = t_coord'(value);
            REG_RADIUS:   sph_r  = t_radius'(value);
            default: ;
        endcase
    endtask

    task automatic set_sphere(t_coord cx, t_coord cy, t_coord cz, t_radius r);
        write_sphere_reg(REG_CENTER_X, APB_DW'(cx));
        write_sphere_reg(REG_CENTER_Y, APB_DW'(cy));
        write_sphere_reg(REG_CENTER_Z, APB_DW'(cz));
        write_sphere_reg(REG_RADIUS,   APB_DW'(r));
    endtask

    // Sends one ray request and queues its expected result on acceptance.
    task automatic send_ray(t_coord ox, t_coord oy, t_coord oz,
                            t_dir dx, t_dir dy, t_dir dz);
        while (idle_on && $urandom_range(99) < 18) begin
            ray_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= ox;
        ray_ch.origin_y <= oy;
        ray_ch.origin_z <= oz;
        ray_ch.dir_x    <= dx;
        ray_ch.dir_y    <= dy;
        ray_ch.dir_z    <= dz;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
        expected_hits.push_back(predict_hit(ox, oy, oz, dx, dy, dz));
    endtask

    task automatic drop_valid();
        ray_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected result is back, then lets the pipe drain.
    task automatic drain();
        drop_valid();
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 5) @(posedge i_clk);
    endtask

    // Receiver stalls and result checking.
    initial begin
        t_hit_result exp_res;
        hit_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hit_ch.valid && hit_ch.ready) begin
                if (expected_hits.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    exp_res = expected_hits.pop_front();
                    if (hit_ch.hit !== exp_res.hit)
                        report_error($sformatf("hit got %b exp %b",
                                               hit_ch.hit, exp_res.hit));
                    if (hit_ch.hit_dist !== exp_res.hit_dist)
                        report_error($sformatf("hit_dist got %0d exp %0d",
                                               hit_ch.hit_dist, exp_res.hit_dist));
                end
            end
            hit_ch.ready <= !(idle_on && $urandom_range(99) < 18);
        end
    end

    function automatic t_dir rand_unit_dir();
        return t_dir'($signed($urandom_range(131072)) - 65536);
    endfunction

    // Directed rays at the corners of the field ranges and the special cases.
    task automatic test_directed();
        set_sphere(t_coord'(0), t_coord'(0), t_coord'(10 <<< 16), t_radius'(2 << 16));
        send_ray('0, '0, '0, '0, '0, 18'sd65536);         // hit ahead
        send_ray('0, '0, '0, '0, '0, -18'sd65536);        // sphere behind
        send_ray('0, '0, t_coord'(10 <<< 16), '0, '0, 18'sd65536); // inside
        send_ray('0, t_coord'(5 <<< 16), '0, '0, '0, 18'sd65536);  // miss
        send_ray('0, t_coord'(2 <<< 16), '0, '0, '0, 18'sd65536);  // tangent
        send_ray('0, '0, '0, 18'sd65536, 18'sd65536, 18'sd65536);  // not normalized
        send_ray('0, '0, '0, 18'h20000, 18'h1FFFF, 18'h20000);     // raw extremes
        send_ray(24'h800000, 24'h800000, 24'h800000, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        send_ray(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 18'h20000, 18'h20000, 18'h20000);
        drain();
        // Extreme sphere so the projection clamps and the distance saturates.
        set_sphere(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF);
        send_ray(24'h800000, 24'h800000, 24'h800000, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        send_ray(24'h800000, 24'h800000, 24'h800000, 18'sd65536, '0, '0);
        send_ray(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 18'h20000, 18'h20000, 18'h20000);
        send_ray('0, '0, '0, '0, '0, '0);
        drain();
        set_sphere(24'h800000, 24'h800000, 24'h800000, 23'd0);
        send_ray(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 18'h20000, 18'h20000, 18'h20000);
        send_ray(24'h800000, 24'h800000, 24'h800000, 18'sd65536, '0, '0);
        send_ray('0, '0, '0, 18'h20000, '0, '0);
        drain();
    endtask

    // Random rays aimed near the sphere, with a share of pure noise.
    task automatic test_random(int count, int spread);
        t_coord ox, oy, oz;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 2) begin
                send_ray(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                         t_dir'($urandom), t_dir'($urandom), t_dir'($urandom));
            end else begin
                ox = t_coord'(int'(sph_cx) + $signed($urandom_range(2 * spread)) - spread);
                oy = t_coord'(int'(sph_cy) + $signed($urandom_range(2 * spread)) - spread);
                oz = t_coord'(int'(sph_cz) + $signed($urandom_range(2 * spread)) - spread);
                send_ray(ox, oy, oz, rand_unit_dir(), rand_unit_dir(), rand_unit_dir());
            end
        end
        drain();
    endtask

    // Stimulus sequence.
    initial begin
        error_count  = 0;
        idle_on      = 1'b1;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        ray_ch.dir_z = '0;
        sph_cx = '0;
        sph_cy = '0;
        sph_cz = '0;
        sph_r  = t_radius'(65536);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sphere first, then directed and random phases.
        test_random(60, 3 << 16);
        test_directed();
        set_sphere(t_coord'(3 <<< 16), t_coord'(-2 <<< 16), t_coord'(1 <<< 16),
                   t_radius'(3 << 16));
        test_random(200, 8 << 16);
        idle_on = 1'b0;
        test_random(150, 8 << 16);
        idle_on = 1'b1;
        set_sphere(t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
                   t_radius'($urandom));
        test_random(170, 1 << 23);
        set_sphere(t_coord'(-40 <<< 16), t_coord'(50 <<< 16), t_coord'(-7 <<< 16),
                   t_radius'(30 << 16));
        test_random(150, 60 << 16);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
design/rsi_pkg.sv
design/rsi_ray_if.sv
design/rsi_hit_if.sv
design/ray_sphere_intersect.sv
design/rsi_checker.sv
tb/ray_sphere_intersect_tb.sv
